// ----- hw/rtl/ecib_pkg.sv -----
// Shared constants, codes, handshake types and search functions for the event channel binder.
`default_nettype none
package ecib_pkg;

	localparam int NUM_CHANNELS = 64;
	localparam int NUM_IRQS     = 32;
	localparam int COUNT_BITS   = 8;

	localparam int CH_W  = $clog2(NUM_CHANNELS);
	localparam int IRQ_W = $clog2(NUM_IRQS);
	localparam int REQ_W = 3;
	localparam int ST_W  = 2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [REQ_W-1:0] REQ_BIND    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_UNBIND  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_MASK    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_UNMASK  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RAISE   = 3'd4;
	localparam logic [REQ_W-1:0] REQ_SERVICE = 3'd5;

	localparam logic [ST_W-1:0] ST_OK           = 2'd0;
	localparam logic [ST_W-1:0] ST_NO_FREE      = 2'd1;
	localparam logic [ST_W-1:0] ST_NONE_PENDING = 2'd2;
	localparam logic [ST_W-1:0] ST_NOT_BOUND    = 2'd3;

	typedef struct packed {
		logic accept;
		logic rd_stage;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	function automatic logic [IRQ_W-1:0] lowest_clear(input logic [NUM_IRQS-1:0] v);
		logic [IRQ_W-1:0] idx;
		idx = '0;
		for (int i = NUM_IRQS - 1; i >= 0; i--) begin
			if (!v[i]) idx = IRQ_W'(i);
		end
		return idx;
	endfunction

	function automatic logic [CH_W-1:0] lowest_set(input logic [NUM_CHANNELS-1:0] v);
		logic [CH_W-1:0] idx;
		idx = '0;
		for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
			if (v[i]) idx = CH_W'(i);
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/event_channel_interrupt_binder_top.sv -----
// Top level of the event channel interrupt binder.
// A request beat is accepted, passes a RAM read stage (accept, RAM read stage, execute) and
// its result beat is then registered; a new request is accepted only after the previous one commits.
// A full output register holds the execute stage until the result beat leaves.
// Reset clears all bindings, pending bits and counts and masks every channel;
// the channel and IRQ map RAMs are not cleared, so no start-up pass is needed.
`default_nettype none
module event_channel_interrupt_binder_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [ecib_pkg::REQ_W-1:0]  req_type,
	input  wire logic [ecib_pkg::CH_W-1:0]   channel,
	input  wire logic [ecib_pkg::IRQ_W-1:0]  irq_number,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [ecib_pkg::IRQ_W-1:0]  irq_out,
	output logic      [ecib_pkg::CH_W-1:0]   channel_out,
	output logic      [ecib_pkg::ST_W-1:0]   status,
	output logic                             closed
);
	import ecib_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ecib_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ecib_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.channel     (channel),
		.irq_number  (irq_number),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.irq_out     (irq_out),
		.channel_out (channel_out),
		.status      (status),
		.closed      (closed)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/ecib_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module ecib_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// ----- hw/rtl/ecib_ctrl.sv -----
// Controller state machine: accept, read stage, execute and result hand-off.
`default_nettype none
module ecib_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  ecib_pkg::sts_t     sts,
	output ecib_pkg::cmd_t     cmd
);
	import ecib_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_EXE  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall     = (state_q != S_IDLE);
	assign cmd.accept   = in_valid && (state_q == S_IDLE);
	assign cmd.rd_stage = (state_q == S_RD);
	// hold the finished beat until the output register has room
	assign cmd.commit   = (state_q == S_EXE) && sts.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (cmd.accept) state_d = S_RD;
			S_RD:   state_d = S_EXE;
			S_EXE:  if (sts.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_accept_to_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == S_RD)
		else $error("accepted beat did not enter read stage");
	a_commit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == S_IDLE && !in_stall)
		else $error("controller not idle after commit");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/ecib_dp.sv -----
// Datapath: channel flags, IRQ counts and maps, priority searches, result register.
`default_nettype none
module ecib_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  ecib_pkg::cmd_t                   cmd,
	output ecib_pkg::sts_t                   sts,
	input  wire logic [ecib_pkg::REQ_W-1:0]  req_type,
	input  wire logic [ecib_pkg::CH_W-1:0]   channel,
	input  wire logic [ecib_pkg::IRQ_W-1:0]  irq_number,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [ecib_pkg::IRQ_W-1:0]  irq_out,
	output logic      [ecib_pkg::CH_W-1:0]   channel_out,
	output logic      [ecib_pkg::ST_W-1:0]   status,
	output logic                             closed
);
	import ecib_pkg::*;

	// request fields
	logic [REQ_W-1:0] req_q;
	logic [CH_W-1:0]  ch_q;
	logic [IRQ_W-1:0] irq_q;

	// read-stage results
	logic [IRQ_W-1:0] v_q;
	logic             was_bound_q;
	logic             no_free_q;
	logic [CH_W-1:0]  svc_idx_q;
	logic             svc_found_q;

	// channel and IRQ flags
	logic [NUM_CHANNELS-1:0] chan_bound_q;
	logic [NUM_CHANNELS-1:0] chan_masked_q;
	logic [NUM_CHANNELS-1:0] chan_pending_q;
	logic [NUM_IRQS-1:0]     nonzero_q;

	logic out_valid_q;

	// RAM ports
	logic [IRQ_W-1:0]      cmap_rd;
	logic [CH_W-1:0]       cmap_raddr;
	logic                  cmap_ren;
	logic                  cmap_we;
	logic [CH_W-1:0]       imap_rd;
	logic                  imap_we;
	logic [COUNT_BITS-1:0] cnt_rd;
	logic [IRQ_W-1:0]      cnt_raddr;
	logic                  cnt_we;
	logic [COUNT_BITS-1:0] cnt_wdata;

	// read-stage logic
	logic [NUM_CHANNELS-1:0] ready_vec;
	logic [CH_W-1:0]         svc_idx;
	logic                    rd_bound;
	logic [IRQ_W-1:0]        v_next;

	// execute-stage logic
	logic [IRQ_W-1:0]      cnt_idx;
	logic [COUNT_BITS-1:0] cnt_cur;
	logic [IRQ_W-1:0]      res_irq;
	logic [CH_W-1:0]       res_ch;
	logic [ST_W-1:0]       res_st;
	logic                  res_cl;
	logic                  nz_set;
	logic                  nz_clr;
	logic                  bound_set;
	logic                  bound_clr;
	logic                  mask_set;
	logic                  mask_clr;
	logic                  pend_set;
	logic                  pend_clr;

	assign ready_vec = chan_pending_q & ~chan_masked_q;
	assign svc_idx   = lowest_set(ready_vec);
	assign rd_bound  = chan_bound_q[ch_q];
	assign v_next    = rd_bound ? cmap_rd : lowest_clear(nonzero_q);

	assign cmap_ren   = cmd.accept || cmd.rd_stage;
	assign cmap_raddr = cmd.accept ? channel : svc_idx;
	assign cnt_raddr  = (req_q == REQ_BIND) ? v_next : irq_q;

	ecib_ram #(.WIDTH(IRQ_W), .DEPTH(NUM_CHANNELS)) u_chan_irq_map (
		.clk     (clk),
		.wr_en   (cmap_we),
		.wr_addr (ch_q),
		.wr_data (v_q),
		.rd_en   (cmap_ren),
		.rd_addr (cmap_raddr),
		.rd_data (cmap_rd)
	);

	ecib_ram #(.WIDTH(CH_W), .DEPTH(NUM_IRQS)) u_irq_chan_map (
		.clk     (clk),
		.wr_en   (imap_we),
		.wr_addr (v_q),
		.wr_data (ch_q),
		.rd_en   (cmd.rd_stage),
		.rd_addr (irq_q),
		.rd_data (imap_rd)
	);

	ecib_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_IRQS)) u_ref_count (
		.clk     (clk),
		.wr_en   (cnt_we),
		.wr_addr (cnt_idx),
		.wr_data (cnt_wdata),
		.rd_en   (cmd.rd_stage),
		.rd_addr (cnt_raddr),
		.rd_data (cnt_rd)
	);

	// a count whose nonzero flag is clear reads as zero
	assign cnt_idx = (req_q == REQ_BIND) ? v_q : irq_q;
	assign cnt_cur = nonzero_q[cnt_idx] ? cnt_rd : '0;

	always_comb begin
		res_irq   = '0;
		res_ch    = '0;
		res_st    = ST_OK;
		res_cl    = 1'b0;
		cnt_wdata = cnt_cur;
		cnt_we    = 1'b0;
		cmap_we   = 1'b0;
		imap_we   = 1'b0;
		nz_set    = 1'b0;
		nz_clr    = 1'b0;
		bound_set = 1'b0;
		bound_clr = 1'b0;
		mask_set  = 1'b0;
		mask_clr  = 1'b0;
		pend_set  = 1'b0;
		pend_clr  = 1'b0;
		case (req_q)
			REQ_BIND: begin
				if (no_free_q) begin
					res_st = ST_NO_FREE;
				end else begin
					res_irq = v_q;
					cnt_we  = 1'b1;
					nz_set  = 1'b1;
					if (cnt_cur != COUNT_MAX) cnt_wdata = cnt_cur + 1'b1;
					if (!was_bound_q) begin
						bound_set = 1'b1;
						cmap_we   = 1'b1;
						imap_we   = 1'b1;
					end
				end
			end
			REQ_UNBIND: begin
				if (cnt_cur == '0) begin
					res_st = ST_NOT_BOUND;
				end else begin
					cnt_we    = 1'b1;
					cnt_wdata = cnt_cur - 1'b1;
					if (cnt_cur == COUNT_BITS'(1)) begin
						nz_clr    = 1'b1;
						bound_clr = 1'b1;
						res_ch    = imap_rd;
						res_cl    = 1'b1;
					end
				end
			end
			REQ_MASK:   mask_set = 1'b1;
			REQ_UNMASK: mask_clr = 1'b1;
			REQ_RAISE:  pend_set = 1'b1;
			REQ_SERVICE: begin
				if (!svc_found_q) begin
					res_st = ST_NONE_PENDING;
				end else begin
					pend_clr = 1'b1;
					res_ch   = svc_idx_q;
					if (chan_bound_q[svc_idx_q]) res_irq = cmap_rd;
					else res_st = ST_NOT_BOUND;
				end
			end
			default: ;
		endcase
		// drop every write unless this is the committing cycle
		cnt_we  = cnt_we && cmd.commit;
		cmap_we = cmap_we && cmd.commit;
		imap_we = imap_we && cmd.commit;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req_type;
			ch_q  <= channel;
			irq_q <= irq_number;
		end
		if (cmd.rd_stage) begin
			v_q         <= v_next;
			was_bound_q <= rd_bound;
			no_free_q   <= !rd_bound && (&nonzero_q);
			svc_idx_q   <= svc_idx;
			svc_found_q <= |ready_vec;
		end
		if (cmd.commit) begin
			irq_out     <= res_irq;
			channel_out <= res_ch;
			status      <= res_st;
			closed      <= res_cl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_bound_q   <= '0;
			chan_masked_q  <= '1;
			chan_pending_q <= '0;
			nonzero_q      <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cmd.commit) begin
				if (bound_set) chan_bound_q[ch_q] <= 1'b1;
				if (bound_clr) chan_bound_q[imap_rd] <= 1'b0;
				if (nz_set) nonzero_q[v_q] <= 1'b1;
				if (nz_clr) nonzero_q[irq_q] <= 1'b0;
				if (mask_set) chan_masked_q[ch_q] <= 1'b1;
				if (mask_clr) chan_masked_q[ch_q] <= 1'b0;
				if (pend_set) chan_pending_q[ch_q] <= 1'b1;
				if (pend_clr) chan_pending_q[svc_idx_q] <= 1'b0;
			end
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || !out_stall;

`ifndef ASSERT_OFF
	a_valid_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit))
		else $error("result beat appeared without a commit");
	a_no_free_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && req_q == REQ_BIND && no_free_q |-> &nonzero_q)
		else $error("no free IRQ reported while a count is zero");
	a_close_unbinds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && bound_clr |=> !chan_bound_q[$past(imap_rd)] && !nonzero_q[$past(irq_q)])
		else $error("closed IRQ left its channel bound");
`endif

endmodule
`default_nettype wire
